// ===== hw/rtl/g2p_pkg.sv =====
// Shared types, constants and helpers for the global-to-patch coordinate map.
// Used by the divide and square-root cells and by the top level.
// No dependencies.
`default_nettype none

package g2p_pkg;

    localparam int FRAC_BITS = 16;

    // Angular/cartesian quotients are at most 1.0, so FRAC_BITS + 1 quotient bits.
    localparam int RATIO_STEPS = FRAC_BITS + 1;
    localparam int ROOT_STEPS  = 64;
    localparam int RDIV_STEPS  = 32;
    localparam int PRE_ROOT    = 6;
    localparam int POST_ROOT   = 3;
    localparam int SIDE_DEPTH  = PRE_ROOT + ROOT_STEPS + POST_ROOT + RDIV_STEPS;
    localparam int RQ_DELAY    = SIDE_DEPTH - RATIO_STEPS;

    localparam logic CFG_INNER = 1'b0;
    localparam logic CFG_OUTER = 1'b1;

    localparam logic [30:0] INNER_RESET = 31'd65536;
    localparam logic [30:0] OUTER_RESET = 31'd655360;

    typedef enum logic [2:0] {
        PATCH_CART = 3'd0,
        PATCH_PX   = 3'd1,
        PATCH_NX   = 3'd2,
        PATCH_PY   = 3'd3,
        PATCH_NY   = 3'd4,
        PATCH_PZ   = 3'd5,
        PATCH_NZ   = 3'd6
    } patch_t;

    // One restoring-divide step: partial remainder, divisor, dividend bits
    // still to shift in (MSB first) and the quotient gathered so far.
    typedef struct packed {
        logic [61:0] rem;
        logic [61:0] den;
        logic [31:0] low;
        logic [31:0] quo;
    } div_word_t;

    // One digit-by-digit square root step.
    typedef struct packed {
        logic [65:0]  rem;
        logic [63:0]  root;
        logic [127:0] rad;
    } root_word_t;

    typedef struct packed {
        patch_t patch;
        logic   is_cart;
        logic   r0_zero;
        logic   radii_eq;
        logic   neg_a;
        logic   neg_b;
        logic   neg_c;
    } side_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/g2p_div_cell.sv =====
// One registered restoring-divide step: one quotient bit per cell.
// Depends on g2p_pkg.
`default_nettype none

module g2p_div_cell (
    input  wire logic              clk,
    input  wire g2p_pkg::div_word_t word_in,
    output g2p_pkg::div_word_t      word_out
);

    logic [62:0]        trial;
    logic               fits;
    g2p_pkg::div_word_t word_next;
    g2p_pkg::div_word_t word_reg;

    always_comb
    begin
        trial          = {word_in.rem, word_in.low[31]};
        fits           = trial >= {1'b0, word_in.den};
        word_next.rem  = fits ? 62'(trial - {1'b0, word_in.den}) : trial[61:0];
        word_next.den  = word_in.den;
        word_next.low  = {word_in.low[30:0], 1'b0};
        word_next.quo  = {word_in.quo[30:0], fits};
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/g2p_sqrt_cell.sv =====
// One registered square-root step: take two radicand bits, settle one root bit.
// Depends on g2p_pkg.
`default_nettype none

module g2p_sqrt_cell (
    input  wire logic               clk,
    input  wire g2p_pkg::root_word_t word_in,
    output g2p_pkg::root_word_t      word_out
);

    logic [67:0]         cur;
    logic [67:0]         trial;
    logic                fits;
    g2p_pkg::root_word_t word_next;
    g2p_pkg::root_word_t word_reg;

    always_comb
    begin
        cur            = {word_in.rem, word_in.rad[127:126]};
        trial          = {2'b00, word_in.root, 2'b01};
        fits           = cur >= trial;
        word_next.rem  = fits ? 66'(cur - trial) : cur[65:0];
        word_next.root = {word_in.root[62:0], fits};
        word_next.rad  = {word_in.rad[125:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/global_to_patch_local_coords.sv =====
// Top level of the global-to-patch coordinate map (cube-in-sphere grid).
// Depends on g2p_pkg, g2p_div_cell and g2p_sqrt_cell.
`default_nettype none

// The block takes one point per clock and never stalls: busy stays low and
// cfg_ready stays high. Every point comes out on done, exactly one cycle wide,
// in the order taken; the receiver must take each word as it appears. The
// radial path is the longest: squaring and partial-product summing registers,
// a row of 64 square-root cells (one root bit each), offset and sign-handling
// registers, and a row of 32 divide cells (one quotient bit each). The angular
// and cartesian ratios run through three parallel rows of FRAC_BITS + 1 divide
// cells and wait in a delay line for the radial result. Write the radii only
// while no point is in flight; a point may follow the write on the next cycle.
module global_to_patch_local_coords (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [30:0]        cfg_data,
    output logic                    done,
    output logic [2:0]              patch_id,
    output logic signed [31:0]      local_a,
    output logic signed [31:0]      local_b,
    output logic signed [31:0]      local_c,
    output logic                    overflow
);

    localparam int RQ_W = g2p_pkg::RATIO_STEPS;
    localparam int NSH_W = 66 + 32;

    logic accept;

    // ---------------- configuration ----------------
    logic [30:0] inner_radius_reg;
    logic [30:0] outer_radius_reg;
    logic [30:0] dm_reg;
    logic [61:0] r0dm_reg;
    logic [61:0] dd_reg;
    logic [61:0] r0sq_reg;
    logic [61:0] r1sq_reg;
    logic        inner_ge;
    logic        radii_eq;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign inner_ge  = inner_radius_reg >= outer_radius_reg;
    assign radii_eq  = inner_radius_reg == outer_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_radius_reg <= g2p_pkg::INNER_RESET;
            outer_radius_reg <= g2p_pkg::OUTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                g2p_pkg::CFG_INNER: inner_radius_reg <= cfg_data;
                g2p_pkg::CFG_OUTER: outer_radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Radius-derived products, refreshed every cycle; stable while points fly.
    always_ff @(posedge clk)
    begin
        dm_reg   <= inner_ge ? 31'(inner_radius_reg - outer_radius_reg)
                             : 31'(outer_radius_reg - inner_radius_reg);
        r0dm_reg <= inner_radius_reg * dm_reg;
        dd_reg   <= dm_reg * dm_reg;
        r0sq_reg <= inner_radius_reg * inner_radius_reg;
        r1sq_reg <= outer_radius_reg * outer_radius_reg;
    end

    // ---------------- input capture ----------------
    logic        v0_reg;
    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [31:0] pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
        end
    end

    // ---------------- classify and set up the ratio lanes ----------------
    logic [31:0]     mx, my, mz, r0e;
    logic            sx, sy, sz;
    logic            in_cube;
    logic [1:0]      axis;
    logic [31:0]     axis_max;
    logic            axis_neg;
    g2p_pkg::patch_t patch_a;
    logic [31:0]     na, da, nb, db, nc, dc;
    logic            nega, negb, negc;
    logic [31:0]     um, vm, wm;
    g2p_pkg::side_t  side_next;

    always_comb
    begin
        mx  = g2p_pkg::mag32(px_reg);
        my  = g2p_pkg::mag32(py_reg);
        mz  = g2p_pkg::mag32(pz_reg);
        sx  = px_reg[31];
        sy  = py_reg[31];
        sz  = pz_reg[31];
        r0e = {1'b0, inner_radius_reg};
        in_cube = (mx <= r0e) && (my <= r0e) && (mz <= r0e);

        // ties favor x, then y
        axis     = 2'd0;
        axis_max = mx;
        axis_neg = sx;
        if (my > axis_max)
        begin
            axis     = 2'd1;
            axis_max = my;
            axis_neg = sy;
        end
        if (mz > axis_max)
        begin
            axis     = 2'd2;
            axis_max = mz;
            axis_neg = sz;
        end

        if (in_cube)
        begin
            patch_a = g2p_pkg::PATCH_CART;
        end
        else
        begin
            patch_a = g2p_pkg::patch_t'(3'({axis, 1'b0}) + 3'd1 + 3'(axis_neg));
        end

        nc   = 32'd0;
        dc   = 32'd1;
        negc = 1'b0;
        case (patch_a)
            g2p_pkg::PATCH_CART:
            begin
                na = mx; da = r0e; nega = sx;
                nb = my; db = r0e; negb = sy;
                nc = mz; dc = r0e; negc = sz;
            end
            g2p_pkg::PATCH_PX:
            begin
                na = mz; da = mx; nega = sz ^ sx;
                nb = my; db = mx; negb = sy ^ sx;
            end
            g2p_pkg::PATCH_NX:
            begin
                na = mz; da = mx; nega = ~(sz ^ sx);
                nb = my; db = mx; negb = sy ^ sx;
            end
            g2p_pkg::PATCH_PY:
            begin
                na = mz; da = my; nega = sz ^ sy;
                nb = mx; db = my; negb = ~(sx ^ sy);
            end
            g2p_pkg::PATCH_NY:
            begin
                na = mz; da = my; nega = ~(sz ^ sy);
                nb = mx; db = my; negb = ~(sx ^ sy);
            end
            g2p_pkg::PATCH_PZ:
            begin
                na = mx; da = mz; nega = ~(sx ^ sz);
                nb = my; db = mz; negb = sy ^ sz;
            end
            g2p_pkg::PATCH_NZ:
            begin
                na = mx; da = mz; nega = ~(sx ^ sz);
                nb = my; db = mz; negb = ~(sy ^ sz);
            end
            default:
            begin
                na = 32'd0; da = 32'd1; nega = 1'b0;
                nb = 32'd0; db = 32'd1; negb = 1'b0;
            end
        endcase

        case (axis)
            2'd1:    begin um = my; vm = mz; wm = mx; end
            2'd2:    begin um = mz; vm = mx; wm = my; end
            default: begin um = mx; vm = my; wm = mz; end
        endcase

        side_next.patch    = patch_a;
        side_next.is_cart  = in_cube;
        side_next.r0_zero  = inner_radius_reg == 31'd0;
        side_next.radii_eq = radii_eq;
        side_next.neg_a    = nega;
        side_next.neg_b    = negb;
        side_next.neg_c    = negc;
    end

    function automatic g2p_pkg::div_word_t ratio_seed(input logic [31:0] n,
                                                      input logic [31:0] d);
        g2p_pkg::div_word_t w;
        w.rem = 62'(n >> 1);
        w.den = 62'(d);
        w.low = {n[0], 31'd0};
        w.quo = 32'd0;
        return w;
    endfunction

    g2p_pkg::div_word_t rat_chain [3][0:g2p_pkg::RATIO_STEPS];
    logic [31:0]        um_reg, vm_reg, wm_reg;

    logic                  valid_line [0:g2p_pkg::SIDE_DEPTH];
    g2p_pkg::side_t        side_line  [0:g2p_pkg::SIDE_DEPTH];

    always_ff @(posedge clk)
    begin
        rat_chain[0][0] <= ratio_seed(na, da);
        rat_chain[1][0] <= ratio_seed(nb, db);
        rat_chain[2][0] <= ratio_seed(nc, dc);
        um_reg          <= um;
        vm_reg          <= vm;
        wm_reg          <= wm;
        side_line[0]    <= side_next;
        for (int i = 1; i <= g2p_pkg::SIDE_DEPTH; i++)
        begin
            side_line[i] <= side_line[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= g2p_pkg::SIDE_DEPTH; i++)
            begin
                valid_line[i] <= 1'b0;
            end
        end
        else
        begin
            valid_line[0] <= v0_reg;
            for (int i = 1; i <= g2p_pkg::SIDE_DEPTH; i++)
            begin
                valid_line[i] <= valid_line[i-1];
            end
        end
    end

    // Three ratio rows of divide cells.
    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        for (genvar k = 0; k < g2p_pkg::RATIO_STEPS; k++)
        begin : g_step
            g2p_div_cell u_step (
                .clk      (clk),
                .word_in  (rat_chain[l][k]),
                .word_out (rat_chain[l][k+1])
            );
        end
    end

    // Hold ratio quotients until the radial result catches up.
    logic [RQ_W-1:0] rqa_line [0:g2p_pkg::RQ_DELAY-1];
    logic [RQ_W-1:0] rqb_line [0:g2p_pkg::RQ_DELAY-1];
    logic [RQ_W-1:0] rqc_line [0:g2p_pkg::RQ_DELAY-1];

    always_ff @(posedge clk)
    begin
        rqa_line[0] <= rat_chain[0][g2p_pkg::RATIO_STEPS].quo[RQ_W-1:0];
        rqb_line[0] <= rat_chain[1][g2p_pkg::RATIO_STEPS].quo[RQ_W-1:0];
        rqc_line[0] <= rat_chain[2][g2p_pkg::RATIO_STEPS].quo[RQ_W-1:0];
        for (int i = 1; i < g2p_pkg::RQ_DELAY; i++)
        begin
            rqa_line[i] <= rqa_line[i-1];
            rqb_line[i] <= rqb_line[i-1];
            rqc_line[i] <= rqc_line[i-1];
        end
    end

    // ---------------- radicand D ----------------
    logic [63:0]  uu1_reg, vv1_reg, ww1_reg;
    logic [63:0]  s2_reg, uu2_reg;
    logic [63:0]  sll_reg, slh_reg, shh_reg;
    logic [63:0]  bll_reg, blh_reg, bhl_reg, bhh_reg;
    logic [63:0]  cll_reg, clh_reg, chl_reg, chh_reg;
    logic [63:0]  s3_reg, s4_reg, s5_reg, s6_reg;
    logic [127:0] a4_reg, b4_reg, c4_reg;
    logic [127:0] t5_reg, b5_reg;
    logic [127:0] d6_reg;
    logic [127:0] bsum, csum;
    logic [128:0] tdiff;

    always_comb
    begin
        bsum  = (128'(bhh_reg) << 64) + (128'(bhl_reg) << 32)
              + (128'(blh_reg) << 32) + 128'(bll_reg);
        csum  = (128'(chh_reg) << 64) + (128'(chl_reg) << 32)
              + (128'(clh_reg) << 32) + 128'(cll_reg);
        tdiff = {1'b0, t5_reg} - {1'b0, b5_reg};
    end

    always_ff @(posedge clk)
    begin
        uu1_reg <= um_reg * um_reg;
        vv1_reg <= vm_reg * vm_reg;
        ww1_reg <= wm_reg * wm_reg;

        s2_reg  <= vv1_reg + ww1_reg;
        uu2_reg <= uu1_reg;

        sll_reg <= s2_reg[31:0] * s2_reg[31:0];
        slh_reg <= s2_reg[31:0] * s2_reg[63:32];
        shh_reg <= s2_reg[63:32] * s2_reg[63:32];
        bll_reg <= r0dm_reg[31:0] * s2_reg[31:0];
        blh_reg <= r0dm_reg[31:0] * s2_reg[63:32];
        bhl_reg <= 64'(r0dm_reg[61:32] * s2_reg[31:0]);
        bhh_reg <= 64'(r0dm_reg[61:32] * s2_reg[63:32]);
        cll_reg <= dd_reg[31:0] * uu2_reg[31:0];
        clh_reg <= dd_reg[31:0] * uu2_reg[63:32];
        chl_reg <= 64'(dd_reg[61:32] * uu2_reg[31:0]);
        chh_reg <= 64'(dd_reg[61:32] * uu2_reg[63:32]);
        s3_reg  <= s2_reg;

        a4_reg  <= {shh_reg, 64'd0} + (128'(slh_reg) << 33) + 128'(sll_reg);
        b4_reg  <= bsum << 2;
        c4_reg  <= csum << 2;
        s4_reg  <= s3_reg;

        t5_reg  <= a4_reg + c4_reg;
        b5_reg  <= b4_reg;
        s5_reg  <= s4_reg;

        // inner inside outer: subtract, clamp at zero; otherwise add
        if (inner_ge)
        begin
            d6_reg <= t5_reg + b5_reg;
        end
        else
        begin
            d6_reg <= tdiff[128] ? 128'd0 : tdiff[127:0];
        end
        s6_reg  <= s5_reg;
    end

    // ---------------- square root row ----------------
    g2p_pkg::root_word_t root_chain [0:g2p_pkg::ROOT_STEPS];
    logic [63:0]         s_line     [0:g2p_pkg::ROOT_STEPS-1];

    always_comb
    begin
        root_chain[0].rem  = 66'd0;
        root_chain[0].root = 64'd0;
        root_chain[0].rad  = d6_reg;
    end

    for (genvar k = 0; k < g2p_pkg::ROOT_STEPS; k++)
    begin : g_root
        g2p_sqrt_cell u_step (
            .clk      (clk),
            .word_in  (root_chain[k]),
            .word_out (root_chain[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        s_line[0] <= s6_reg;
        for (int i = 1; i < g2p_pkg::ROOT_STEPS; i++)
        begin
            s_line[i] <= s_line[i-1];
        end
    end

    // ---------------- numerator and divide setup ----------------
    logic [65:0]        pos_reg;
    logic [65:0]        num_reg;
    logic               neg_p2_reg;
    logic [NSH_W-1:0]   nsh;
    logic [NSH_W-1:0]   dd_lim;
    g2p_pkg::div_word_t rdiv_chain [0:g2p_pkg::RDIV_STEPS];
    logic               big_line   [0:g2p_pkg::RDIV_STEPS-1];
    logic               neg_line   [0:g2p_pkg::RDIV_STEPS-1];
    logic               big_p3_reg;
    logic               neg_p3_reg;

    always_comb
    begin
        nsh    = NSH_W'(num_reg) << g2p_pkg::FRAC_BITS;
        dd_lim = NSH_W'(dd_reg) << 32;
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= 66'(r0sq_reg) + 66'(s_line[g2p_pkg::ROOT_STEPS-1])
                 + 66'(root_chain[g2p_pkg::ROOT_STEPS].root);

        neg_p2_reg <= pos_reg < 66'(r1sq_reg);
        num_reg    <= (pos_reg < 66'(r1sq_reg)) ? 66'(66'(r1sq_reg) - pos_reg)
                                               : 66'(pos_reg - 66'(r1sq_reg));

        // quotient of 2^32 or more saturates in any case
        big_p3_reg        <= nsh >= dd_lim;
        neg_p3_reg        <= neg_p2_reg;
        rdiv_chain[0].rem <= nsh[93:32];
        rdiv_chain[0].den <= dd_reg;
        rdiv_chain[0].low <= nsh[31:0];
        rdiv_chain[0].quo <= 32'd0;

        big_line[0] <= big_p3_reg;
        neg_line[0] <= neg_p3_reg;
        for (int i = 1; i < g2p_pkg::RDIV_STEPS; i++)
        begin
            big_line[i] <= big_line[i-1];
            neg_line[i] <= neg_line[i-1];
        end
    end

    // rdiv_chain[0] is the setup register; the row follows it.
    g2p_pkg::div_word_t rdiv_out;

    for (genvar k = 0; k < g2p_pkg::RDIV_STEPS - 1; k++)
    begin : g_rdiv
        g2p_div_cell u_step (
            .clk      (clk),
            .word_in  (rdiv_chain[k]),
            .word_out (rdiv_chain[k+1])
        );
    end

    g2p_div_cell u_rdiv_last (
        .clk      (clk),
        .word_in  (rdiv_chain[g2p_pkg::RDIV_STEPS-1]),
        .word_out (rdiv_out)
    );

    assign rdiv_chain[g2p_pkg::RDIV_STEPS] = rdiv_out;

    // ---------------- combine and drive the result word ----------------
    g2p_pkg::side_t side_end;
    logic [31:0]    qa, qb, qc, qr;
    logic           r_big, r_neg, r_sat;
    logic [31:0]    r_mag;
    logic [31:0]    la_next, lb_next, lc_next;
    logic           ovf_next;

    logic           done_reg;
    logic [2:0]     patch_reg;
    logic [31:0]    la_reg, lb_reg, lc_reg;
    logic           ovf_reg;

    always_comb
    begin
        side_end = side_line[g2p_pkg::SIDE_DEPTH];
        qa = 32'(rqa_line[g2p_pkg::RQ_DELAY-1]);
        qb = 32'(rqb_line[g2p_pkg::RQ_DELAY-1]);
        qc = 32'(rqc_line[g2p_pkg::RQ_DELAY-1]);
        qr = rdiv_chain[g2p_pkg::RDIV_STEPS].quo;
        r_big = big_line[g2p_pkg::RDIV_STEPS-1];
        r_neg = neg_line[g2p_pkg::RDIV_STEPS-1];

        r_sat = r_big || (r_neg ? (qr > 32'h8000_0000) : qr[31]);
        r_mag = r_sat ? (r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : qr;

        la_next  = side_end.neg_a ? 32'(-qa) : qa;
        lb_next  = side_end.neg_b ? 32'(-qb) : qb;
        ovf_next = side_end.radii_eq;

        if (side_end.is_cart)
        begin
            lc_next = side_end.neg_c ? 32'(-qc) : qc;
            if (side_end.r0_zero)
            begin
                la_next  = 32'd0;
                lb_next  = 32'd0;
                lc_next  = 32'd0;
                ovf_next = 1'b1;
            end
        end
        else if (side_end.radii_eq)
        begin
            lc_next = 32'd0;
        end
        else
        begin
            lc_next  = r_neg ? 32'(-r_mag) : r_mag;
            ovf_next = r_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_line[g2p_pkg::SIDE_DEPTH];
        end
    end

    always_ff @(posedge clk)
    begin
        patch_reg <= side_end.patch;
        la_reg    <= la_next;
        lb_reg    <= lb_next;
        lc_reg    <= lc_next;
        ovf_reg   <= ovf_next;
    end

    assign done     = done_reg;
    assign patch_id = patch_reg;
    assign local_a  = la_reg;
    assign local_b  = lb_reg;
    assign local_c  = lc_reg;
    assign overflow = ovf_reg;

endmodule

`default_nettype wire
